>>> hw/rtl/rtsp_pkg.sv
// Shared types and constants for the routing table shortest-path engine.
// No dependencies; the core imports this package, rtsp_ram does not.
`timescale 1ns / 1ps
`default_nettype none

package rtsp_pkg;

	localparam int NODES_DEF     = 8;
	localparam int COST_BITS_DEF = 16;
	localparam int NODE_W        = 4;
	localparam int LINK_W        = 16;
	localparam int DIST_W        = 20;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic [LINK_W-1:0] link_cost;
		logic              link_present;
	} cmd_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] path_cost;
		logic              reachable;
		logic [NODE_W-1:0] via_node;
	} rsp_word_t;

	// One table entry: link part, distance part, via node.
	typedef struct packed {
		logic              lok;
		logic [LINK_W-1:0] lcost;
		logic              dok;
		logic [DIST_W-1:0] dcost;
		logic [NODE_W-1:0] via;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

endpackage

`default_nettype wire

>>> hw/rtl/rtsp_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rtsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

>>> hw/rtl/routing_table_shortest_path_core.sv
// Routing table engine: link load, Floyd-Warshall route compute, pair query.
// Depends on rtsp_pkg and rtsp_ram.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | ports                       | handshake
//  ----------+-----------------------------+-------------------------------
//  command   | start, busy, cmd            | taken when start & !busy
//  result    | rsp_valid, rsp              | one-cycle strobe, no back-pressure
//
// Load: busy in ST_LOADW after the accept (read-modify-write of the entry).
// Query: busy in ST_QRSP; the result strobes in the cycle after the accept.
// Compute: busy through a copy pass over all NODES^2 entries (ST_INIT), then an
// ST_IK step and an ST_J sweep over j for each (k,i) row, paced by the single table
// RAM with two read ports and one write port, then a drain step (ST_DRAIN).
// Reset: valid flops mark every entry absent/unreachable; no clearing pass.
// The receiver cannot stall; a result is never held.

module routing_table_shortest_path_core
	import rtsp_pkg::*;
#(
	parameter int NODES     = NODES_DEF,
	parameter int COST_BITS = COST_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire cmd_word_t cmd,
	output logic           rsp_valid,
	output rsp_word_t      rsp
);

	localparam int CELLS = NODES * NODES;
	localparam int AW    = $clog2(CELLS);
	localparam int NW    = $clog2(NODES);
	localparam logic [LINK_W-1:0] COST_MASK =
		(COST_BITS >= LINK_W) ? {LINK_W{1'b1}} : LINK_W'((1 << COST_BITS) - 1);
	localparam logic [NW-1:0] LAST = NW'(NODES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOADW = 3'd1;
	localparam logic [2:0] ST_QRSP  = 3'd2;
	localparam logic [2:0] ST_INIT  = 3'd3;
	localparam logic [2:0] ST_IK    = 3'd4;
	localparam logic [2:0] ST_J     = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;

	function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] r,
		input logic [NW-1:0] c);
		return AW'(AW'(r) * AW'(NODES)) + AW'(c);
	endfunction

	logic [2:0]       state_q;
	logic [NW-1:0]    i_q, j_q, k_q;
	logic [CELLS-1:0] link_vld_q, dist_vld_q;

	// payload holding registers
	logic [AW-1:0]     addr_q;
	logic              ld_present_q;
	logic [LINK_W-1:0] ld_cost_q;
	logic              q_inr_q, q_vld_q;
	logic [NODE_W-1:0] q_from_q;
	logic              dik_ok_q;
	logic [DIST_W-1:0] dik_cost_q;

	// write pipeline stage
	logic              init_s1, relax_s1;
	logic [AW-1:0]     waddr_s1;
	logic              diag_s1, lvld_s1;
	logic [NODE_W-1:0] via_s1;

	logic [AW-1:0]     raddr_a, raddr_b, cmd_addr;
	logic              we;
	logic [AW-1:0]     waddr;
	cell_t             wcell, rd_a, rd_b;
	logic [CELL_W-1:0] rdata_a, rdata_b;
	logic              cmd_inr, accept;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] sat;
	logic              upd;

	assign rd_a = cell_t'(rdata_a);
	assign rd_b = cell_t'(rdata_b);

	assign cmd_inr  = (5'(cmd.from_node) < 5'(NODES)) && (5'(cmd.to_node) < 5'(NODES));
	assign cmd_addr = cell_addr(cmd.from_node[NW-1:0], cmd.to_node[NW-1:0]);
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;

	// relaxation: d(i,k) held, d(k,j) on port A, d(i,j) on port B
	assign sum = (DIST_W+1)'(dik_cost_q) + (DIST_W+1)'(rd_a.dcost);
	assign sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	assign upd = dik_ok_q && rd_a.dok && (!rd_b.dok || (sat < rd_b.dcost));

	always_comb begin
		raddr_a = cmd_addr;
		raddr_b = cell_addr(i_q, j_q);
		unique case (state_q)
			ST_INIT: raddr_a = cell_addr(i_q, j_q);
			ST_IK:   raddr_a = cell_addr(i_q, k_q);
			ST_J:    raddr_a = cell_addr(k_q, j_q);
			default: raddr_a = cmd_addr;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = waddr_s1;
		wcell = rd_a;
		priority if (state_q == ST_LOADW) begin
			// keep the distance part, replace the link part
			we          = 1'b1;
			waddr       = addr_q;
			wcell.lok   = ld_present_q;
			wcell.lcost = ld_present_q ? ld_cost_q : '0;
		end else if (init_s1) begin
			we          = 1'b1;
			wcell.dok   = diag_s1 || (lvld_s1 && rd_a.lok);
			wcell.dcost = (!diag_s1 && lvld_s1 && rd_a.lok) ? DIST_W'(rd_a.lcost) : '0;
			wcell.via   = via_s1;
		end else if (relax_s1) begin
			// rewrite the (i,j) word with its own link part
			we          = upd;
			wcell       = rd_b;
			wcell.dok   = 1'b1;
			wcell.dcost = sat;
			wcell.via   = via_s1;
		end else begin
			// no table write this cycle
			we = 1'b0;
		end
	end

	rtsp_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_table (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wcell),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// sequencer and valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			link_vld_q <= '0;
			dist_vld_q <= '0;
			init_s1    <= 1'b0;
			relax_s1   <= 1'b0;
		end else begin
			init_s1  <= 1'b0;
			relax_s1 <= 1'b0;
			if (init_s1) begin
				dist_vld_q[waddr_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (cmd.operation == OP_LOAD) begin
							if (cmd_inr) state_q <= ST_LOADW;
						end else if (cmd.operation == OP_COMPUTE) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_INIT;
						end else if (cmd.operation == OP_QUERY) begin
							state_q <= ST_QRSP;
						end else begin
							// drop the unused operation code
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LOADW: begin
					link_vld_q[addr_q] <= 1'b1;
					state_q            <= ST_IDLE;
				end
				ST_QRSP: state_q <= ST_IDLE;
				ST_INIT: begin
					init_s1 <= 1'b1;
					j_q     <= j_q + 1'b1;
					if (j_q == LAST) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q == LAST) begin
							i_q     <= '0;
							k_q     <= '0;
							state_q <= ST_IK;
						end
					end
				end
				ST_IK: begin
					j_q     <= '0;
					state_q <= ST_J;
				end
				ST_J: begin
					relax_s1 <= 1'b1;
					j_q      <= j_q + 1'b1;
					if (j_q == LAST) begin
						state_q <= ST_IK;
						i_q     <= i_q + 1'b1;
						if (i_q == LAST) begin
							i_q <= '0;
							k_q <= k_q + 1'b1;
							if (k_q == LAST) state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q       <= cmd_addr;
			ld_present_q <= cmd.link_present;
			ld_cost_q    <= cmd.link_cost & COST_MASK;
			q_inr_q      <= cmd_inr;
			q_from_q     <= cmd.from_node;
			q_vld_q      <= cmd_inr && dist_vld_q[cmd_addr];
		end
		if (state_q == ST_J && j_q == '0) begin
			// port A now holds d(i,k) from the row-start read
			dik_ok_q   <= rd_a.dok;
			dik_cost_q <= rd_a.dcost;
		end
		waddr_s1 <= cell_addr(i_q, j_q);
		diag_s1  <= (i_q == j_q);
		lvld_s1  <= link_vld_q[cell_addr(i_q, j_q)];
		via_s1   <= (state_q == ST_J) ? NODE_W'(k_q) : NODE_W'(i_q);
	end

	// result word: one-cycle strobe after a query accept
	assign rsp_valid     = (state_q == ST_QRSP);
	assign rsp.reachable = q_inr_q && q_vld_q && rd_a.dok;
	assign rsp.path_cost = rsp.reachable ? rd_a.dcost : '0;
	assign rsp.via_node  = !q_inr_q ? q_from_q : (q_vld_q ? rd_a.via : '0);

`ifndef NO_ASSERTIONS
	a_rsp_follows_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(start && !busy && cmd.operation == OP_QUERY))
		else $error("result without a query");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(init_s1 && relax_s1) && !(state_q == ST_LOADW && (init_s1 || relax_s1)))
		else $error("two table writers at once");
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.reachable) |-> (rsp.path_cost == '0))
		else $error("unreachable pair with nonzero cost");
	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_IDLE && !relax_s1))
		else $error("relax write after drain");
`endif

endmodule

`default_nettype wire
